/* src/prg_pkg.sv */
// Shared types, constants and helpers for the primary ray generator.
package prg_pkg;

    // Pipeline depths of the iterative units (one result bit per stage)
    localparam int CAM_MAG_W  = 16;                     // |pixel - principal point| bits
    localparam int CAM_FRAC   = 20;                     // Q.16 result over Q20.4 divisor
    localparam int CAM_STEPS  = CAM_MAG_W + CAM_FRAC;   // quotient bits
    localparam int SQRT_IN_W  = 62;                     // sum of three 30-bit squares
    localparam int SQRT_STEPS = SQRT_IN_W / 2;          // root bits
    localparam int DDIV_STEPS = 15;                     // direction magnitude bits
    localparam int NORM_MSB   = 29;                     // normalized max lies in [2^29, 2^30)

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_PRINCIPAL = 3'd0,
        REG_FOCAL     = 3'd1,
        REG_ROT_X     = 3'd2,
        REG_ROT_Y     = 3'd3,
        REG_ROT_Z     = 3'd4,
        REG_CENTER_X  = 3'd5,
        REG_CENTER_Y  = 3'd6,
        REG_CENTER_Z  = 3'd7
    } cfg_idx_t;

    // One finished result item
    typedef struct packed {
        logic        saturated;
        logic        degenerate;
        logic [31:0] point_z;
        logic [31:0] point_y;
        logic [31:0] point_x;
        logic [15:0] dir_z;
        logic [15:0] dir_y;
        logic [15:0] dir_x;
    } result_t;

    // Position of the highest set bit (0 when no bit is set)
    function automatic logic [5:0] msb_pos(input logic [54:0] v);
        logic [5:0] pos;
        pos = '0;
        for (int i = 0; i < 55; i++) begin
            if (v[i]) pos = 6'(i);
        end
        return pos;
    endfunction

endpackage

/* src/primary_ray_generator_unit.sv */
// Top level of the pinhole-camera primary ray generator.
//
//  channel   direction  item contents
//  s_        in         pixel_u, pixel_v, hit_distance
//  m_        out        dir_x/y/z, point_x/y/z; tuser degenerate, saturated
//  cfg_      in         register write: index, data
//
// Throughput is one item per cycle while the output buffer has room; the
// path from acceptance to m_tvalid runs through the 36-stage camera divider,
// the 31-stage square root and the 15-stage direction divider plus ten
// single stages after the input register, and the output buffer write.
// Reset clears the valid bits and the registers to their defaults.
// A stall halts the whole pipeline only when the two-entry output buffer
// is full, so s_tready depends on registered state alone.
module primary_ray_generator_unit import prg_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,    // pixel_u[15:0], pixel_v[31:16], hit_distance[63:32]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,    // dir_x, dir_y, dir_z (16 each), point_x, point_y, point_z (32 each)
    output logic [1:0]   m_tuser,    // degenerate[0], saturated[1]
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [47:0]  cfg_wdata
);

    localparam logic signed [35:0] P_MAX = 36'sd2147483647;
    localparam logic signed [35:0] P_MIN = -36'sd2147483648;

    // ---------------- configuration registers ----------------
    logic [31:0] pp_reg;
    logic [47:0] fl_reg;
    logic [47:0] rot_reg [3];
    logic [31:0] ctr_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pp_reg <= '0;
            fl_reg <= 48'd16777472;
            for (int i = 0; i < 3; i++) begin
                rot_reg[i] <= '0;
                ctr_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                REG_PRINCIPAL: pp_reg     <= cfg_wdata[31:0];
                REG_FOCAL:     fl_reg     <= cfg_wdata;
                REG_ROT_X:     rot_reg[0] <= cfg_wdata;
                REG_ROT_Y:     rot_reg[1] <= cfg_wdata;
                REG_ROT_Z:     rot_reg[2] <= cfg_wdata;
                REG_CENTER_X:  ctr_reg[0] <= cfg_wdata[31:0];
                REG_CENTER_Y:  ctr_reg[1] <= cfg_wdata[31:0];
                REG_CENTER_Z:  ctr_reg[2] <= cfg_wdata[31:0];
                default:       pp_reg     <= pp_reg;
            endcase
        end
    end

    // zero focal length acts as one LSB
    logic [23:0] fx;
    logic [23:0] fy;
    assign fx = (fl_reg[23:0]  == '0) ? 24'd1 : fl_reg[23:0];
    assign fy = (fl_reg[47:24] == '0) ? 24'd1 : fl_reg[47:24];

    logic en;
    assign s_tready = en;

    // ---------------- stage 1: offsets from principal point ----------------
    logic        v1_reg;
    logic [15:0] magx_reg, magy_reg;
    logic        negx_reg, negy_reg;
    logic [31:0] t1_reg;
    logic [16:0] du, dv;

    assign du = {1'b0, s_tdata[15:0]}  - {1'b0, pp_reg[15:0]};
    assign dv = {1'b0, s_tdata[31:16]} - {1'b0, pp_reg[31:16]};

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en)  v1_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            magx_reg <= du[16] ? 16'(-du) : du[15:0];
            magy_reg <= dv[16] ? 16'(-dv) : dv[15:0];
            negx_reg <= du[16];
            negy_reg <= ~dv[16];    // camera y is the negated quotient
            t1_reg   <= s_tdata[63:32];
        end
    end

    // ---------------- camera dividers ----------------
    logic                 cvx, cvy, cam_v;
    logic [CAM_STEPS-1:0] qx, qy;
    logic                 cnx, cny;
    logic [31:0]          t2;

    prg_cam_div u_div_x (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v1_reg),
        .in_mag(magx_reg), .in_neg(negx_reg), .divisor(fx),
        .out_valid(cvx), .out_q(qx), .out_neg(cnx)
    );

    prg_cam_div u_div_y (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(v1_reg),
        .in_mag(magy_reg), .in_neg(negy_reg), .divisor(fy),
        .out_valid(cvy), .out_q(qy), .out_neg(cny)
    );

    prg_delay #(.W(32), .N(CAM_STEPS)) u_dly_t0 (
        .aclk(aclk), .en(en), .din(t1_reg), .dout(t2)
    );

    assign cam_v = cvx & cvy;

    // ---------------- stage P: rotation products ----------------
    logic               vp_reg;
    logic signed [55:0] prod_reg [3][3];
    logic [31:0]        tp_reg;
    logic signed [36:0] camx, camy;

    assign camx = cnx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    assign camy = cny ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

    always_ff @(posedge aclk) begin
        if (!aresetn) vp_reg <= 1'b0;
        else if (en)  vp_reg <= cam_v;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i][0] <= 56'($signed(rot_reg[i][15:0])  * camx);
                prod_reg[i][1] <= 56'($signed(rot_reg[i][31:16]) * camy);
                // camera z is -1.0: a shifted, negated entry
                prod_reg[i][2] <= -(56'($signed(rot_reg[i][47:32])) <<< 16);
            end
            tp_reg <= t2;
        end
    end

    // ---------------- stage C: dot products ----------------
    logic               vc_reg;
    logic signed [55:0] d_reg [3];
    logic [31:0]        tc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vc_reg <= 1'b0;
        else if (en)  vc_reg <= vp_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) d_reg[i] <= prod_reg[i][0] + prod_reg[i][1] + prod_reg[i][2];
            tc_reg <= tp_reg;
        end
    end

    // ---------------- stage D: magnitudes and maximum ----------------
    logic        vd_reg;
    logic [54:0] ad_reg [3];
    logic [2:0]  negd_reg;
    logic [54:0] md_reg;
    logic [31:0] td_reg;
    logic [54:0] a_abs [3];
    logic [54:0] a_max;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_abs[i] = d_reg[i][55] ? 55'(-d_reg[i]) : d_reg[i][54:0];
        end
        a_max = a_abs[0];
        if (a_abs[1] > a_max) a_max = a_abs[1];
        if (a_abs[2] > a_max) a_max = a_abs[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vd_reg <= 1'b0;
        else if (en)  vd_reg <= vc_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                ad_reg[i]   <= a_abs[i];
                negd_reg[i] <= d_reg[i][55];
            end
            md_reg <= a_max;
            td_reg <= tc_reg;
        end
    end

    // ---------------- stage E: leading-one search ----------------
    logic        ve_reg;
    logic [54:0] ae_reg [3];
    logic [2:0]  nege_reg;
    logic [5:0]  pos_reg;
    logic        dege_reg;
    logic [31:0] te_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) ve_reg <= 1'b0;
        else if (en)  ve_reg <= vd_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ae_reg   <= ad_reg;
            nege_reg <= negd_reg;
            pos_reg  <= msb_pos(md_reg);
            dege_reg <= md_reg == '0;
            te_reg   <= td_reg;
        end
    end

    // ---------------- stage F: common normalizing shift ----------------
    logic        vf_reg;
    logic [29:0] af_reg [3];
    logic [2:0]  negf_reg;
    logic        degf_reg;
    logic [31:0] tf_reg;
    logic [54:0] a_sh [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (pos_reg >= 6'(NORM_MSB)) a_sh[i] = ae_reg[i] >> (pos_reg - 6'(NORM_MSB));
            else                         a_sh[i] = ae_reg[i] << (6'(NORM_MSB) - pos_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vf_reg <= 1'b0;
        else if (en)  vf_reg <= ve_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) af_reg[i] <= a_sh[i][29:0];
            negf_reg <= nege_reg;
            degf_reg <= dege_reg;
            tf_reg   <= te_reg;
        end
    end

    // ---------------- stage G: squares ----------------
    logic        vg_reg;
    logic [59:0] sq_reg [3];
    logic [29:0] ag_reg [3];
    logic [2:0]  negg_reg;
    logic        degg_reg;
    logic [31:0] tg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vg_reg <= 1'b0;
        else if (en)  vg_reg <= vf_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) sq_reg[i] <= 60'(af_reg[i]) * 60'(af_reg[i]);
            ag_reg   <= af_reg;
            negg_reg <= negf_reg;
            degg_reg <= degf_reg;
            tg_reg   <= tf_reg;
        end
    end

    // ---------------- stage H: sum of squares ----------------
    logic                 vh_reg;
    logic [SQRT_IN_W-1:0] sum_reg;
    logic [125:0]         side_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vh_reg <= 1'b0;
        else if (en)  vh_reg <= vg_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg    <= 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]);
            side_h_reg <= {tg_reg, degg_reg, negg_reg, ag_reg[2], ag_reg[1], ag_reg[0]};
        end
    end

    // ---------------- square root ----------------
    logic                  sq_v;
    logic [SQRT_STEPS-1:0] len;
    logic [125:0]          side_s;

    prg_isqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(vh_reg),
        .in_sum(sum_reg), .out_valid(sq_v), .out_root(len)
    );

    prg_delay #(.W(126), .N(SQRT_STEPS)) u_dly_s (
        .aclk(aclk), .en(en), .din(side_h_reg), .dout(side_s)
    );

    // ---------------- stage I: divider operands ----------------
    logic        vi_reg;
    logic [45:0] num_reg [3];
    logic [31:0] den_reg;
    logic [35:0] side_i_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) vi_reg <= 1'b0;
        else if (en)  vi_reg <= sq_v;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                num_reg[i] <= {1'b0, side_s[30*i +: 30], 15'b0} + 46'(len);
            end
            den_reg    <= {len, 1'b0};
            side_i_reg <= side_s[125:90];
        end
    end

    // ---------------- direction dividers ----------------
    logic [2:0]            dv_v;
    logic [DDIV_STEPS-1:0] qd [3];
    logic [35:0]           side_d;

    for (genvar i = 0; i < 3; i++) begin : g_ddiv
        prg_dir_div u_ddiv (
            .aclk(aclk), .aresetn(aresetn), .en(en), .in_valid(vi_reg),
            .in_num(num_reg[i]), .in_den(den_reg),
            .out_valid(dv_v[i]), .out_q(qd[i])
        );
    end

    prg_delay #(.W(36), .N(DDIV_STEPS)) u_dly_d (
        .aclk(aclk), .en(en), .din(side_i_reg), .dout(side_d)
    );

    // ---------------- stage J: clamp, sign, scale by distance ----------------
    logic        vj_reg;
    logic [15:0] dirj_reg [3];
    logic [46:0] pj_reg [3];
    logic [2:0]  negj_reg;
    logic        degj_reg;
    logic [14:0] dmag [3];
    logic [31:0] td;
    logic        degd;
    logic [2:0]  negd;

    assign td   = side_d[35:4];
    assign degd = side_d[3];
    assign negd = side_d[2:0];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (degd)                     dmag[i] = '0;
            else if (qd[i] > 15'd16384)   dmag[i] = 15'd16384;
            else                          dmag[i] = qd[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vj_reg <= 1'b0;
        else if (en)  vj_reg <= &dv_v;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dirj_reg[i] <= negd[i] ? 16'(-{1'b0, dmag[i]}) : {1'b0, dmag[i]};
                pj_reg[i]   <= 47'(dmag[i]) * 47'(td);
            end
            negj_reg <= negd;
            degj_reg <= degd;
        end
    end

    // ---------------- stage K: world point with saturation ----------------
    logic    vk_reg;
    result_t res_reg;
    result_t res_next;

    always_comb begin
        logic [47:0]        rnd;
        logic signed [35:0] pv;
        logic [31:0]        pt [3];
        logic               sat;
        sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            rnd = {1'b0, pj_reg[i]} + 48'd8192;
            pv  = 36'($signed(ctr_reg[i]));
            if (negj_reg[i]) pv = pv - $signed({2'b0, rnd[47:14]});
            else             pv = pv + $signed({2'b0, rnd[47:14]});
            if (pv > P_MAX) begin
                pt[i] = P_MAX[31:0];
                sat   = 1'b1;
            end else if (pv < P_MIN) begin
                pt[i] = P_MIN[31:0];
                sat   = 1'b1;
            end else begin
                pt[i] = pv[31:0];
            end
        end
        res_next.dir_x      = dirj_reg[0];
        res_next.dir_y      = dirj_reg[1];
        res_next.dir_z      = dirj_reg[2];
        res_next.point_x    = pt[0];
        res_next.point_y    = pt[1];
        res_next.point_z    = pt[2];
        res_next.degenerate = degj_reg;
        res_next.saturated  = sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vk_reg <= 1'b0;
        else if (en)  vk_reg <= vj_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) res_reg <= res_next;
    end

    // ---------------- output buffer ----------------
    result_t m_res;

    prg_out_buf u_obuf (
        .aclk(aclk), .aresetn(aresetn), .push(vk_reg && en), .push_data(res_reg),
        .room(en), .m_valid(m_tvalid), .m_ready(m_tready), .m_data(m_res)
    );

    assign m_tdata = {m_res.point_z, m_res.point_y, m_res.point_x,
                      m_res.dir_z, m_res.dir_y, m_res.dir_x};
    assign m_tuser = {m_res.saturated, m_res.degenerate};

endmodule

/* src/prg_delay.sv */
// Enabled shift line that carries side data alongside a pipelined unit.
module prg_delay #(
    parameter int W = 8,
    parameter int N = 4
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [N];

    // Shift by one tap per enabled cycle
    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= din;
            for (int i = 1; i < N; i++) tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign dout = tap_reg[N-1];

endmodule

/* src/prg_cam_div.sv */
// Pipelined restoring divider for the camera-space x and y terms.
module prg_cam_div import prg_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [CAM_MAG_W-1:0] in_mag,
    input  logic                 in_neg,
    input  logic [23:0]          divisor,
    output logic                 out_valid,
    output logic [CAM_STEPS-1:0] out_q,
    output logic                 out_neg
);

    localparam int N = CAM_STEPS;

    logic [23:0]  rem_reg [N];
    logic [N-1:0] q_reg   [N];
    logic         neg_reg [N];
    logic         vld_reg [N];
    logic [23:0]  rem_src [N];
    logic [N-1:0] q_src   [N];
    logic         neg_src [N];
    logic         vld_src [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [24:0] tmp;
        logic        ge;

        // Stage inputs: ports for the first step, previous stage otherwise
        if (k == 0) begin : g_first
            assign rem_src[k] = '0;
            assign q_src[k]   = {in_mag, {CAM_FRAC{1'b0}}};
            assign neg_src[k] = in_neg;
            assign vld_src[k] = in_valid;
        end else begin : g_next
            assign rem_src[k] = rem_reg[k-1];
            assign q_src[k]   = q_reg[k-1];
            assign neg_src[k] = neg_reg[k-1];
            assign vld_src[k] = vld_reg[k-1];
        end

        // Shift in one dividend bit, subtract when it fits
        assign tmp = {rem_src[k], q_src[k][N-1]};
        assign ge  = tmp >= {1'b0, divisor};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_src[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? 24'(tmp - {1'b0, divisor}) : tmp[23:0];
                q_reg[k]   <= {q_src[k][N-2:0], ge};
                neg_reg[k] <= neg_src[k];
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_q     = q_reg[N-1];
    assign out_neg   = neg_reg[N-1];

endmodule

/* src/prg_isqrt.sv */
// Pipelined integer square root, one root bit per stage.
module prg_isqrt import prg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [SQRT_IN_W-1:0]  in_sum,
    output logic                  out_valid,
    output logic [SQRT_STEPS-1:0] out_root
);

    localparam int N  = SQRT_STEPS;
    localparam int RW = N + 2;          // remainder stays below 2*root+1

    logic [RW-1:0]        rem_reg  [N];
    logic [N-1:0]         root_reg [N];
    logic [SQRT_IN_W-1:0] sv_reg   [N];
    logic                 vld_reg  [N];
    logic [RW-1:0]        rem_src  [N];
    logic [N-1:0]         root_src [N];
    logic [SQRT_IN_W-1:0] sv_src   [N];
    logic                 vld_src  [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [RW+1:0] rt;
        logic [RW+1:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_src[k]  = '0;
            assign root_src[k] = '0;
            assign sv_src[k]   = in_sum;
            assign vld_src[k]  = in_valid;
        end else begin : g_next
            assign rem_src[k]  = rem_reg[k-1];
            assign root_src[k] = root_reg[k-1];
            assign sv_src[k]   = sv_reg[k-1];
            assign vld_src[k]  = vld_reg[k-1];
        end

        // Bring down two radicand bits, try 4*root+1
        assign rt    = {rem_src[k], sv_src[k][SQRT_IN_W-1 -: 2]};
        assign trial = {2'b00, root_src[k], 2'b01};
        assign ge    = rt >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_src[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? RW'(rt - trial) : rt[RW-1:0];
                root_reg[k] <= {root_src[k][N-2:0], ge};
                sv_reg[k]   <= {sv_src[k][SQRT_IN_W-3:0], 2'b00};
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_root  = root_reg[N-1];

endmodule

/* src/prg_dir_div.sv */
// Pipelined divider for one direction magnitude (quotient below 2^15).
module prg_dir_div import prg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [45:0]           in_num,
    input  logic [31:0]           in_den,
    output logic                  out_valid,
    output logic [DDIV_STEPS-1:0] out_q
);

    localparam int N = DDIV_STEPS;

    logic [45:0]  rem_reg [N];
    logic [31:0]  den_reg [N];
    logic [N-1:0] q_reg   [N];
    logic         vld_reg [N];
    logic [45:0]  rem_src [N];
    logic [31:0]  den_src [N];
    logic [N-1:0] q_src   [N];
    logic         vld_src [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [45:0] dsh;
        logic        ge;

        if (k == 0) begin : g_first
            assign rem_src[k] = in_num;
            assign den_src[k] = in_den;
            assign q_src[k]   = '0;
            assign vld_src[k] = in_valid;
        end else begin : g_next
            assign rem_src[k] = rem_reg[k-1];
            assign den_src[k] = den_reg[k-1];
            assign q_src[k]   = q_reg[k-1];
            assign vld_src[k] = vld_reg[k-1];
        end

        // Quotient bit N-1-k: compare against the aligned divisor
        assign dsh = {14'b0, den_src[k]} << (N - 1 - k);
        assign ge  = rem_src[k] >= dsh;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_src[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? rem_src[k] - dsh : rem_src[k];
                den_reg[k] <= den_src[k];
                q_reg[k]   <= {q_src[k][N-2:0], ge};
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_q     = q_reg[N-1];

endmodule

/* src/prg_out_buf.sv */
// Two-entry output buffer; its room flag is the pipeline advance.
module prg_out_buf import prg_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    room,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    result_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;

    assign pop     = m_valid && m_ready;
    assign room    = cnt_reg != 2'd2;
    assign m_valid = cnt_reg != 2'd0;
    assign m_data  = mem_reg[rd_ptr_reg];

    // Occupancy
    always_comb begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* src/prg_checker.sv */
// Port-level checks for the primary ray generator, bound to the top level.
module prg_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata,
    input logic [1:0]   m_tuser
);

    // Output buffer is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled item holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result item changed");

    // Degenerate ray: zero direction and no clamp
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[47:0] == '0 && !m_tuser[1])
        else $error("degenerate item with nonzero direction or clamp");

    // Direction components stay within one unit
    a_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            $signed(m_tdata[15:0])  <= 16'sd16384 && $signed(m_tdata[15:0])  >= -16'sd16384 &&
            $signed(m_tdata[31:16]) <= 16'sd16384 && $signed(m_tdata[31:16]) >= -16'sd16384 &&
            $signed(m_tdata[47:32]) <= 16'sd16384 && $signed(m_tdata[47:32]) >= -16'sd16384)
        else $error("direction component out of range");

endmodule

bind primary_ray_generator_unit prg_checker u_prg_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);

/* tb/prg_ray_checker.sv */
// Ray checker: predicts each ray from the pixel items and compares the results.
module prg_ray_checker import prg_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [63:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [143:0] m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [47:0]  cfg_wdata,
    output int           fail_count,
    output int           rays_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] principal;
    logic [47:0] focal;
    logic [47:0] rot_rows [3];
    logic [31:0] centers [3];
    result_t     ray_queue [$];

    // Integer square root, floor
    function automatic longint unsigned root_floor(input longint unsigned s);
        longint unsigned r, bit_v;
        r = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > s) bit_v >>= 2;
        while (bit_v != 0) begin
            if (s >= r + bit_v) begin
                s -= r + bit_v;
                r = (r >> 1) + bit_v;
            end else begin
                r >>= 1;
            end
            bit_v >>= 2;
        end
        return r;
    endfunction

    // Signed Q.16 camera coordinate: magnitude truncated toward zero
    function automatic longint cam_coord(input longint n, input longint unsigned f);
        longint unsigned q;
        q = ((n < 0 ? -n : n) << 20) / f;
        return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic result_t trace_ray(input logic [63:0] pix);
        longint unsigned fx, fy, mx, s, len, q, rr;
        longint unsigned mag [3];
        longint unsigned dmag [3];
        longint cam [3];
        longint d [3];
        longint p;
        logic neg [3];
        logic sat;
        result_t res;
        fx = focal[23:0];
        fy = focal[47:24];
        if (fx == 0) fx = 1;
        if (fy == 0) fy = 1;
        cam[0] = cam_coord(longint'(pix[15:0]) - longint'(principal[15:0]), fx);
        cam[1] = -cam_coord(longint'(pix[31:16]) - longint'(principal[31:16]), fy);
        cam[2] = -65536;
        mx = 0;
        sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            d[i] = 0;
            for (int k = 0; k < 3; k++)
                d[i] += longint'($signed(rot_rows[i][16*k +: 16])) * cam[k];
            neg[i] = d[i] < 0;
            mag[i] = neg[i] ? -d[i] : d[i];
            dmag[i] = 0;
            if (mag[i] > mx) mx = mag[i];
        end
        res = '0;
        res.degenerate = (mx == 0);
        if (mx != 0) begin
            while (mx >= (64'd1 << 30)) begin
                mx >>= 1;
                for (int i = 0; i < 3; i++) mag[i] >>= 1;
            end
            while (mx < (64'd1 << 29)) begin
                mx <<= 1;
                for (int i = 0; i < 3; i++) mag[i] <<= 1;
            end
            s = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
            len = root_floor(s);
            for (int i = 0; i < 3; i++) begin
                q = (mag[i] * 32768 + len) / (2 * len);
                if (q > 16384) q = 16384;
                dmag[i] = q;
            end
        end
        for (int i = 0; i < 3; i++) begin
            rr = (dmag[i] * 64'(pix[63:32]) + 8192) >> 14;
            p = longint'($signed(centers[i])) + (neg[i] ? -longint'(rr) : longint'(rr));
            if (p > 64'sd2147483647) begin p = 64'sd2147483647; sat = 1'b1; end
            if (p < -64'sd2147483648) begin p = -64'sd2147483648; sat = 1'b1; end
            case (i)
                0: begin res.dir_x = 16'(neg[i] ? -dmag[i] : dmag[i]); res.point_x = p[31:0]; end
                1: begin res.dir_y = 16'(neg[i] ? -dmag[i] : dmag[i]); res.point_y = p[31:0]; end
                default: begin
                    res.dir_z = 16'(neg[i] ? -dmag[i] : dmag[i]);
                    res.point_z = p[31:0];
                end
            endcase
        end
        res.saturated = sat;
        return res;
    endfunction

    assign rays_pending = ray_queue.size();

    // Register shadow, prediction and comparison
    always @(posedge aclk) begin
        result_t got, want;
        if (!aresetn) begin
            principal <= '0;
            focal <= 48'h0000_0100_0100;
            for (int i = 0; i < 3; i++) begin
                rot_rows[i] <= '0;
                centers[i] <= '0;
            end
            fail_count <= 0;
            ray_queue.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_addr))
                    REG_PRINCIPAL: principal <= cfg_wdata[31:0];
                    REG_FOCAL:     focal <= cfg_wdata;
                    REG_ROT_X:     rot_rows[0] <= cfg_wdata;
                    REG_ROT_Y:     rot_rows[1] <= cfg_wdata;
                    REG_ROT_Z:     rot_rows[2] <= cfg_wdata;
                    REG_CENTER_X:  centers[0] <= cfg_wdata[31:0];
                    REG_CENTER_Y:  centers[1] <= cfg_wdata[31:0];
                    REG_CENTER_Z:  centers[2] <= cfg_wdata[31:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) ray_queue.push_back(trace_ray(s_tdata));
            if (m_tvalid && m_tready) begin
                got = {m_tuser[1], m_tuser[0], m_tdata};
                if (ray_queue.size() == 0) begin
                    $display("%0t: unexpected ray item, expected none, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = ray_queue.pop_front();
                    if (got !== want) begin
                        $display("%0t: ray mismatch", $time);
                        $display("  expected dir %h %h %h pt %h %h %h deg %b sat %b",
                            want.dir_x, want.dir_y, want.dir_z, want.point_x,
                            want.point_y, want.point_z, want.degenerate, want.saturated);
                        $display("  actual   dir %h %h %h pt %h %h %h deg %b sat %b",
                            got.dir_x, got.dir_y, got.dir_z, got.point_x,
                            got.point_y, got.point_z, got.degenerate, got.saturated);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

/* tb/tb_primary_ray_generator_unit.sv */
// Testbench top: pixel stimulus, camera setups, stalls and the verdict.
module tb_primary_ray_generator_unit import prg_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 93;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [143:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_wr_en = 0;
    logic [2:0]   cfg_addr = '0;
    logic [47:0]  cfg_wdata = '0;
    int           fail_count;
    int           rays_pending;
    bit           calm_phase = 0;
    bit           hold_sink = 0;

    always #1 aclk = ~aclk;

    primary_ray_generator_unit u_dut (.*);

    prg_ray_checker u_chk (.*);

    // Write one configuration register
    task automatic write_reg(input cfg_idx_t idx, input logic [47:0] val);
        cfg_wr_en <= 1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    // Offer one pixel item, at times with a random gap first, until accepted
    task automatic send_pixel(input logic [15:0] u, input logic [15:0] v,
                              input logic [31:0] hit_dist);
        int gap;
        if (!calm_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {hit_dist, v, u};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_rays();
        s_tvalid <= 0;
        @(posedge aclk);
        while (rays_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Random Q1.14 entry, mostly within the unit range
    function automatic logic [15:0] rand_rot();
        int r;
        r = $urandom_range(0, 32768) - 16384;
        return ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535)) : r[15:0];
    endfunction

    task automatic random_camera(input int mode);
        logic [31:0] cen;
        write_reg(REG_PRINCIPAL, {16'h0, 16'($urandom_range(0, 65535)),
                                  16'($urandom_range(0, 65535))});
        write_reg(REG_FOCAL, mode == 0 ? 48'h0 :
            {24'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 20)),
             24'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 20))});
        write_reg(REG_ROT_X, {rand_rot(), rand_rot(), rand_rot()});
        write_reg(REG_ROT_Y, {rand_rot(), rand_rot(), rand_rot()});
        write_reg(REG_ROT_Z, {rand_rot(), rand_rot(), rand_rot()});
        for (int i = 0; i < 3; i++) begin
            cen = (mode == 1) ? (i[0] ? 32'h7FFF_FF00 : 32'h8000_0100) : $urandom();
            write_reg(cfg_idx_t'(REG_CENTER_X + i), {16'h0, cen});
        end
    endtask

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        m_tready <= 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink) begin
                m_tready <= 0;
                n = 0;
                while (n < 300) begin
                    @(posedge aclk);
                    n++;
                end
                hold_sink = 0;
            end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_tready <= 1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        logic [31:0] hit_dist;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: identity camera, pixel and distance extremes
        write_reg(REG_PRINCIPAL, {16'd0, 16'd2048, 16'd2048});
        write_reg(REG_FOCAL, {24'd25600, 24'd25600});
        write_reg(REG_ROT_X, {16'd0, 16'd0, 16'd16384});
        write_reg(REG_ROT_Y, {16'd0, 16'd16384, 16'd0});
        write_reg(REG_ROT_Z, {16'd16384, 16'd0, 16'd0});
        write_reg(REG_CENTER_X, 48'h0);
        write_reg(REG_CENTER_Y, 48'h0);
        write_reg(REG_CENTER_Z, 48'h0);
        send_pixel(16'd0, 16'd0, 32'd0);
        send_pixel(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_pixel(16'd2048, 16'd2048, 32'h0001_0000);
        send_pixel(16'hFFFF, 16'd0, 32'h8000_0000);
        send_pixel(16'd0, 16'hFFFF, 32'd1);
        drain_rays();
        // Zero rotation: degenerate ray, point is the center
        write_reg(REG_ROT_X, 48'h0);
        write_reg(REG_ROT_Y, 48'h0);
        write_reg(REG_ROT_Z, 48'h0);
        write_reg(REG_CENTER_X, 48'h8000_0000);
        write_reg(REG_CENTER_Y, 48'h7FFF_FFFF);
        send_pixel(16'd100, 16'd200, 32'hFFFF_FFFF);
        send_pixel(16'd0, 16'd0, 32'd0);
        drain_rays();
        // Zero focal lengths, extreme centers for saturation, full-scale rotation
        write_reg(REG_FOCAL, 48'h0);
        write_reg(REG_ROT_X, {16'h8000, 16'h7FFF, 16'hC000});
        write_reg(REG_ROT_Y, {16'h7FFF, 16'h8000, 16'h4000});
        write_reg(REG_ROT_Z, {16'hC000, 16'h4000, 16'h8000});
        write_reg(REG_CENTER_X, 48'h7FFF_FFFF);
        write_reg(REG_CENTER_Y, 48'h8000_0000);
        write_reg(REG_CENTER_Z, 48'h7FFF_0000);
        send_pixel(16'hFFFF, 16'd0, 32'hFFFF_FFFF);
        send_pixel(16'd0, 16'hFFFF, 32'hFFFF_FFFF);
        send_pixel(16'd1, 16'd1, 32'h0000_8000);
        send_pixel(16'h8000, 16'h7FFF, 32'h1234_5678);
        drain_rays();
        write_reg(REG_FOCAL, 48'hFFFF_FFFF_FFFF);
        send_pixel(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_pixel(16'd0, 16'd0, 32'h0000_0001);
        drain_rays();

        // Random phases with fresh cameras; long receiver hold-off in one
        for (int ph = 0; ph < 8; ph++) begin
            random_camera(ph == 2 ? 0 : (ph == 5 ? 1 : 2));
            if (ph == 3) hold_sink = 1;
            if (ph == 7) calm_phase = 1;
            for (int n = 0; n < 80; n++) begin
                case ($urandom_range(0, 3))
                    0: hit_dist = $urandom();
                    1: hit_dist = $urandom_range(0, 32'h0010_0000);
                    2: hit_dist = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0, 16'($urandom())};
                    default: hit_dist = $urandom_range(0, 32'h0100_0000);
                endcase
                send_pixel(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           hit_dist);
            end
            drain_rays();
        end
        repeat (LATENCY + 20) @(posedge aclk);
        if (fail_count == 0 && rays_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Run limit
    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

/* files.f */
src/prg_pkg.sv
src/prg_delay.sv
src/prg_cam_div.sv
src/prg_isqrt.sv
src/prg_dir_div.sv
src/prg_out_buf.sv
src/primary_ray_generator_unit.sv
src/prg_checker.sv
tb/prg_ray_checker.sv
tb/tb_primary_ray_generator_unit.sv
